### rtl/slt_pkg.sv
package slt_pkg;

  localparam int PosBitsDefault    = 16;
  localparam int KwMaxLenDefault   = 6;
  localparam int OutPosW           = 16;
  localparam int KindW             = 5;
  localparam int ErrW              = 2;
  localparam int MaxResults        = 3;
  localparam int CountW            = 2;
  localparam int QueueDepth        = 2;
  localparam int KwCount           = 7;
  localparam int KwTextLen         = 6;

  localparam logic [KindW-1:0] KindEof   = 5'd0;
  localparam logic [KindW-1:0] KindInt   = 5'd13;
  localparam logic [KindW-1:0] KindIdent = 5'd14;
  localparam logic [KindW-1:0] KindKw0   = 5'd15;

  localparam logic [ErrW-1:0] ErrNone    = 2'd0;
  localparam logic [ErrW-1:0] ErrBadChar = 2'd1;
  localparam logic [ErrW-1:0] ErrBadInt  = 2'd2;

  localparam logic [7:0] CharNewline    = 8'h0A;
  localparam logic [7:0] CharUnderscore = "_";
  localparam logic [7:0] CharX          = "x";
  localparam logic [7:0] CharB          = "b";

  localparam logic [7:0] KwText [KwCount][KwTextLen] = '{
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "s", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"e", "x", "t", "e", "r", "n"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00}
  };
  localparam logic [2:0] KwLen [KwCount] = '{3'd2, 3'd2, 3'd3, 3'd6, 3'd6, 3'd2, 3'd4};

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ErrW-1:0]    err_code;
    logic [OutPosW-1:0] start_index;
    logic [OutPosW-1:0] end_index;
    logic [OutPosW-1:0] start_line;
    logic [OutPosW-1:0] start_column;
    logic [OutPosW-1:0] end_line;
    logic [OutPosW-1:0] end_column;
  } res_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ErrW-1:0]    err_code;
    logic [OutPosW-1:0] start_index;
    logic [OutPosW-1:0] end_index;
    logic [OutPosW-1:0] start_line;
    logic [OutPosW-1:0] start_column;
    logic [OutPosW-1:0] end_line;
    logic [OutPosW-1:0] end_column;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0]               count;
    res_t [MaxResults-1:0]           res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [9:0] {
    ModeIdle = 10'b00_0000_0001,
    ModeWord = 10'b00_0000_0010,
    ModeZero = 10'b00_0000_0100,
    ModeHexP = 10'b00_0000_1000,
    ModeHex  = 10'b00_0001_0000,
    ModeBinP = 10'b00_0010_0000,
    ModeBin  = 10'b00_0100_0000,
    ModeOct  = 10'b00_1000_0000,
    ModeDec  = 10'b01_0000_0000,
    ModeTail = 10'b10_0000_0000
  } mode_e;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == " ") || (c == CharNewline) || (c == 8'h09) || (c == 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_dig(c) || is_alpha(c) || (c == CharUnderscore);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic [KindW-1:0] punct_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    case (c)
      "{":     k = 5'd1;
      "(":     k = 5'd2;
      "}":     k = 5'd3;
      ")":     k = 5'd4;
      ";":     k = 5'd5;
      "=":     k = 5'd6;
      "+":     k = 5'd7;
      "-":     k = 5'd8;
      ",":     k = 5'd9;
      "*":     k = 5'd10;
      "/":     k = 5'd11;
      "%":     k = 5'd12;
      default: k = KindEof;
    endcase
    return k;
  endfunction

endpackage

### rtl/slt_stream_if.sv
interface slt_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/slt_front.sv
module slt_front #(
  parameter int POS_BITS        = slt_pkg::PosBitsDefault,
  parameter int KEYWORD_MAX_LEN = slt_pkg::KwMaxLenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slt_stream_if.sink            src,
  input  slt_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output slt_pkg::bundle_t      bundle_o
);

  localparam int WlW = $clog2(KEYWORD_MAX_LEN + 2);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [KEYWORD_MAX_LEN-1:0][7:0] prefix_t;

  localparam pos_t PosOne = POS_BITS'(1);

  slt_pkg::mode_e mode_q, mode_d;
  pos_t cidx_q, cidx_d, cline_q, cline_d, ccol_q, ccol_d;
  pos_t tsi_q, tsi_d, tsl_q, tsl_d, tsc_q, tsc_d;
  prefix_t prefix_q, prefix_d;
  logic [WlW-1:0] wlen_q, wlen_d;
  logic [1:0] flags_q, flags_d;
  logic halt_q, halt_d;

  logic accept;
  logic [7:0] c;
  logic take, adv, idle_go, fin, bad_ch;
  logic [3:0] cv;
  slt_pkg::res_t cand [4];
  logic [slt_pkg::CountW-1:0] n;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + PosOne;
  endfunction

  function automatic logic [slt_pkg::OutPosW-1:0] o16(input pos_t v);
    logic [POS_BITS+slt_pkg::OutPosW-1:0] w;
    w = {{slt_pkg::OutPosW{1'b0}}, v};
    return w[slt_pkg::OutPosW-1:0];
  endfunction

  function automatic slt_pkg::res_t mk(input logic [slt_pkg::KindW-1:0] kind,
                                       input logic [slt_pkg::ErrW-1:0] err,
                                       input pos_t si, input pos_t sl, input pos_t sc,
                                       input pos_t ei, input pos_t el, input pos_t ec);
    slt_pkg::res_t r;
    r.kind         = kind;
    r.err_code     = err;
    r.start_index  = o16(si);
    r.start_line   = o16(sl);
    r.start_column = o16(sc);
    r.end_index    = o16(ei);
    r.end_line     = o16(el);
    r.end_column   = o16(ec);
    return r;
  endfunction

  function automatic logic [slt_pkg::KindW-1:0] word_kind(input prefix_t p,
                                                          input logic [WlW-1:0] len);
    logic [slt_pkg::KindW-1:0] k;
    logic hit;
    k = slt_pkg::KindIdent;
    for (int i = 0; i < slt_pkg::KwCount; i++) begin
      hit = (len == WlW'(slt_pkg::KwLen[i]));
      for (int j = 0; j < slt_pkg::KwTextLen; j++) begin
        if ((j < int'(slt_pkg::KwLen[i])) && (p[j] != slt_pkg::KwText[i][j])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = slt_pkg::KindKw0 + slt_pkg::KindW'(i);
      end
    end
    return k;
  endfunction

  assign src.ready = !q_status_i.full;
  assign accept    = src.valid && src.ready;
  assign c         = src.data.ch;
  assign take      = src.data.ch_valid && !halt_q;

  always_comb begin
    mode_d   = mode_q;
    cidx_d   = cidx_q;
    cline_d  = cline_q;
    ccol_d   = ccol_q;
    tsi_d    = tsi_q;
    tsl_d    = tsl_q;
    tsc_d    = tsc_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    flags_d  = flags_q;
    halt_d   = halt_q;
    adv      = 1'b0;
    idle_go  = 1'b0;
    fin      = 1'b0;
    bad_ch   = 1'b0;
    cv       = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (take) begin
      case (mode_q)
        slt_pkg::ModeWord: begin
          if (slt_pkg::is_word(c)) begin
            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
              if ((wlen_q == WlW'(i)) && (wlen_q < WlW'(KEYWORD_MAX_LEN))) begin
                prefix_d[i] = c;
              end
            end
            if (wlen_q <= WlW'(KEYWORD_MAX_LEN)) begin
              wlen_d = wlen_q + WlW'(1);
            end
            adv = 1'b1;
          end else begin
            cv[0]   = 1'b1;
            cand[0] = mk(word_kind(prefix_q, wlen_q), slt_pkg::ErrNone,
                         tsi_q, tsl_q, tsc_q, cidx_q, cline_q, ccol_q);
            mode_d  = slt_pkg::ModeIdle;
            idle_go = 1'b1;
          end
        end
        slt_pkg::ModeZero: begin
          if ((c == slt_pkg::CharX) || (c == "X")) begin
            mode_d  = slt_pkg::ModeHexP;
            flags_d = flags_q | 2'b01;
            adv     = 1'b1;
          end else if ((c == slt_pkg::CharB) || (c == "B")) begin
            mode_d  = slt_pkg::ModeBinP;
            flags_d = flags_q | 2'b01;
            adv     = 1'b1;
          end else if (c inside {["0":"7"]}) begin
            mode_d = slt_pkg::ModeOct;
            adv    = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        slt_pkg::ModeHexP, slt_pkg::ModeHex: begin
          if (slt_pkg::is_hex(c)) begin
            mode_d  = slt_pkg::ModeHex;
            flags_d = flags_q & 2'b10;
            adv     = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        slt_pkg::ModeBinP, slt_pkg::ModeBin: begin
          if ((c == "0") || (c == "1")) begin
            mode_d  = slt_pkg::ModeBin;
            flags_d = flags_q & 2'b10;
            adv     = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        slt_pkg::ModeOct: begin
          adv = c inside {["0":"7"]};
          fin = !adv;
        end
        slt_pkg::ModeDec: begin
          adv = slt_pkg::is_dig(c);
          fin = !adv;
        end
        slt_pkg::ModeTail: begin
          adv = slt_pkg::is_word(c);
          fin = !adv;
        end
        default: begin
          mode_d  = slt_pkg::ModeIdle;
          idle_go = 1'b1;
        end
      endcase

      if (fin) begin
        if (slt_pkg::is_word(c)) begin
          mode_d  = slt_pkg::ModeTail;
          flags_d = flags_d | 2'b10;
          adv     = 1'b1;
        end else begin
          mode_d = slt_pkg::ModeIdle;
          cv[0]  = 1'b1;
          if (flags_d != 2'b00) begin
            cand[0] = mk(slt_pkg::KindEof, slt_pkg::ErrBadInt,
                         tsi_q, tsl_q, tsc_q, cidx_q, cline_q, ccol_q);
            halt_d  = 1'b1;
          end else begin
            cand[0] = mk(slt_pkg::KindInt, slt_pkg::ErrNone,
                         tsi_q, tsl_q, tsc_q, cidx_q, cline_q, ccol_q);
            idle_go = 1'b1;
          end
        end
      end

      if (idle_go) begin
        tsi_d = cidx_q;
        tsl_d = cline_q;
        tsc_d = ccol_q;
        adv   = 1'b1;
        if (slt_pkg::is_ws(c)) begin
          mode_d = slt_pkg::ModeIdle;
        end else if (slt_pkg::punct_kind(c) != slt_pkg::KindEof) begin
          cv[1] = 1'b1;
        end else if (slt_pkg::is_dig(c)) begin
          mode_d  = (c == "0") ? slt_pkg::ModeZero : slt_pkg::ModeDec;
          flags_d = 2'b00;
        end else if (slt_pkg::is_alpha(c) || (c == slt_pkg::CharUnderscore)) begin
          mode_d      = slt_pkg::ModeWord;
          prefix_d[0] = c;
          wlen_d      = WlW'(1);
        end else begin
          cv[1]  = 1'b1;
          bad_ch = 1'b1;
          halt_d = 1'b1;
        end
      end

      if (adv) begin
        cidx_d = sat_inc(cidx_q);
        ccol_d = sat_inc(ccol_q);
        if (c == slt_pkg::CharNewline) begin
          cline_d = sat_inc(cline_q);
          ccol_d  = PosOne;
        end
      end

      cand[1] = mk(bad_ch ? slt_pkg::KindEof : slt_pkg::punct_kind(c),
                   bad_ch ? slt_pkg::ErrBadChar : slt_pkg::ErrNone,
                   cidx_q, cline_q, ccol_q, cidx_d, cline_d, ccol_d);
    end

    if (src.data.end_of_source) begin
      if (!halt_d) begin
        if (mode_d == slt_pkg::ModeWord) begin
          cv[2]   = 1'b1;
          cand[2] = mk(word_kind(prefix_d, wlen_d), slt_pkg::ErrNone,
                       tsi_d, tsl_d, tsc_d, cidx_d, cline_d, ccol_d);
        end else if (mode_d != slt_pkg::ModeIdle) begin
          cv[2] = 1'b1;
          if (flags_d != 2'b00) begin
            cand[2] = mk(slt_pkg::KindEof, slt_pkg::ErrBadInt,
                         tsi_d, tsl_d, tsc_d, cidx_d, cline_d, ccol_d);
            halt_d  = 1'b1;
          end else begin
            cand[2] = mk(slt_pkg::KindInt, slt_pkg::ErrNone,
                         tsi_d, tsl_d, tsc_d, cidx_d, cline_d, ccol_d);
          end
        end
      end
      if (!halt_d) begin
        cv[3]   = 1'b1;
        cand[3] = mk(slt_pkg::KindEof, slt_pkg::ErrNone,
                     cidx_d, cline_d, ccol_d, cidx_d, cline_d, ccol_d);
      end
      mode_d  = slt_pkg::ModeIdle;
      cidx_d  = '0;
      cline_d = PosOne;
      ccol_d  = PosOne;
      tsi_d   = '0;
      tsl_d   = PosOne;
      tsc_d   = PosOne;
      wlen_d  = '0;
      flags_d = 2'b00;
      halt_d  = 1'b0;
    end
  end

  always_comb begin
    bundle_o = '0;
    n        = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        bundle_o.res[n] = cand[i];
        n               = n + slt_pkg::CountW'(1);
      end
    end
    bundle_o.count = n;
  end

  assign push_o = accept && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= slt_pkg::ModeIdle;
      cidx_q  <= '0;
      cline_q <= PosOne;
      ccol_q  <= PosOne;
      tsi_q   <= '0;
      tsl_q   <= PosOne;
      tsc_q   <= PosOne;
      wlen_q  <= '0;
      flags_q <= 2'b00;
      halt_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      cidx_q  <= cidx_d;
      cline_q <= cline_d;
      ccol_q  <= ccol_d;
      tsi_q   <= tsi_d;
      tsl_q   <= tsl_d;
      tsc_q   <= tsc_d;
      wlen_q  <= wlen_d;
      flags_q <= flags_d;
      halt_q  <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prefix_q <= prefix_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && halt_q && !src.data.end_of_source) |-> !push_o)
    else $error("halted front produced a result");

  a_halt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> (mode_q == slt_pkg::ModeIdle))
    else $error("halted front left mid token");

endmodule

### rtl/slt_queue.sv
module slt_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  slt_pkg::bundle_t       bundle_i,
  input  logic                   pop_i,
  output slt_pkg::bundle_t       head_o,
  output slt_pkg::queue_status_t status_o
);

  localparam int PtrW = $clog2(slt_pkg::QueueDepth);
  localparam int CntW = $clog2(slt_pkg::QueueDepth + 1);

  slt_pkg::bundle_t mem_q [slt_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CntW'(slt_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(slt_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(slt_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("pop from empty queue");

endmodule

### rtl/slt_back.sv
module slt_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slt_pkg::bundle_t       head_i,
  input  slt_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  slt_stream_if.source           tok
);

  logic [slt_pkg::CountW-1:0] sub_q, sub_d;
  logic is_last;
  slt_pkg::res_t cur;

  assign cur     = head_i.res[sub_q];
  assign is_last = (sub_q == head_i.count - slt_pkg::CountW'(1));

  assign tok.valid             = !q_status_i.empty;
  assign tok.data.kind         = cur.kind;
  assign tok.data.err_code     = cur.err_code;
  assign tok.data.start_index  = cur.start_index;
  assign tok.data.end_index    = cur.end_index;
  assign tok.data.start_line   = cur.start_line;
  assign tok.data.start_column = cur.start_column;
  assign tok.data.end_line     = cur.end_line;
  assign tok.data.end_column   = cur.end_column;
  assign tok.data.last         = is_last;

  assign pop_o = tok.valid && tok.ready && is_last;

  always_comb begin
    sub_d = sub_q;
    if (tok.valid && tok.ready) begin
      sub_d = is_last ? '0 : sub_q + slt_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok.valid |-> ((head_i.count != '0) && (sub_q < head_i.count)))
    else $error("result index outside bundle");

endmodule

### rtl/source_lexer_tokenizer_unit.sv
// Channel  Role    Payload                                           Accepted when
// src_i    sink    ch, ch_valid, end_of_source                       valid && ready
// tok_o    source  kind, err_code, start/end index/line/column, last  valid && ready
//
// One byte enters per cycle; scanning and classification finish in the cycle of acceptance.
// Results leave one per cycle from a two-bundle queue; a byte with up to three results
// holds its queue entry until the last of them has left, and the input stalls only when the queue is full.
// Reset returns the scanner to position index 0, line 1, column 1; no clearing pass.
// Output stalls back up through the queue to src_i.ready without losing state.
module source_lexer_tokenizer_unit #(
  parameter int POS_BITS        = slt_pkg::PosBitsDefault,
  parameter int KEYWORD_MAX_LEN = slt_pkg::KwMaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slt_stream_if.sink   src_i,
  slt_stream_if.source tok_o
);

  logic                   push;
  logic                   pop;
  slt_pkg::bundle_t       bundle;
  slt_pkg::bundle_t       head;
  slt_pkg::queue_status_t q_status;

  slt_front #(
    .POS_BITS        (POS_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src        (src_i),
    .q_status_i (q_status),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  slt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  slt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .tok        (tok_o)
  );

endmodule

### dv/source_lexer_tokenizer_unit_tb.sv
module source_lexer_tokenizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int    KeepLen    = 6;
  localparam string PunctChars = "{(});=+-,*/%";
  localparam string Blanks     = " \t\015\n";
  localparam string WordHead   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string WordChars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string HexDigits  = "0123456789abcdefABCDEF";
  localparam string OctDigits  = "01234567";
  localparam string DecDigits  = "0123456789";

  typedef enum logic [2:0] {
    ClsSpace,
    ClsPunct,
    ClsDigit,
    ClsLetter,
    ClsScore,
    ClsBad
  } char_cls_e;

  logic clk = 1'b0;
  logic rst_n;

  int src_gap_pct   = 27;
  int tok_stall_pct = 60;
  int mismatches    = 0;

  slt_stream_if #(.item_t(in_item_t))  src_if ();
  slt_stream_if #(.item_t(out_item_t)) tok_if ();

  source_lexer_tokenizer_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .src_i (src_if),
    .tok_o (tok_if)
  );

  always #5ns clk = ~clk;

  // lexer state mirror
  mode_e       scan_state;
  logic [15:0] at_index, at_line, at_column;
  logic [15:0] tok_index, tok_line, tok_column;
  logic [7:0]  word_text [KeepLen];
  int          word_len;
  logic        bare_prefix, bad_tail, stopped;
  int          step_results;
  out_item_t   tok_expected [$];

  function automatic logic [KindW-1:0] punct_code(input logic [7:0] c);
    for (int i = 0; i < PunctChars.len(); i++) begin
      if (PunctChars[i] == c) return KindW'(i + 1);
    end
    return KindEof;
  endfunction

  function automatic char_cls_e char_class(input logic [7:0] c);
    if (c == " " || c == CharNewline || c == 8'h09 || c == 8'h0D) return ClsSpace;
    if (punct_code(c) != KindEof) return ClsPunct;
    if (c >= "0" && c <= "9") return ClsDigit;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return ClsLetter;
    if (c == CharUnderscore) return ClsScore;
    return ClsBad;
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    char_cls_e cls;
    cls = char_class(c);
    return cls == ClsDigit || cls == ClsLetter || cls == ClsScore;
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return char_class(c) == ClsDigit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_state();
    scan_state  = ModeIdle;
    at_index    = 16'd0;
    at_line     = 16'd1;
    at_column   = 16'd1;
    tok_index   = 16'd0;
    tok_line    = 16'd1;
    tok_column  = 16'd1;
    word_len    = 0;
    bare_prefix = 1'b0;
    bad_tail    = 1'b0;
    stopped     = 1'b0;
  endfunction

  function automatic void move_past(input logic [7:0] c);
    at_index  = bump(at_index);
    at_column = bump(at_column);
    if (c == CharNewline) begin
      at_line   = bump(at_line);
      at_column = 16'd1;
    end
  endfunction

  function automatic void open_span();
    tok_index  = at_index;
    tok_line   = at_line;
    tok_column = at_column;
  endfunction

  function automatic void push_token(input logic [KindW-1:0] k, input logic [ErrW-1:0] e);
    out_item_t t;
    if (step_results >= MaxResults) return;
    t = '{kind: k, err_code: e, start_index: tok_index, end_index: at_index,
          start_line: tok_line, start_column: tok_column, end_line: at_line,
          end_column: at_column, last: 1'b0};
    tok_expected.push_back(t);
    step_results++;
  endfunction

  function automatic void close_word();
    logic [KindW-1:0] k;
    logic             same;
    k = KindIdent;
    if (word_len <= KeepLen) begin
      for (int i = 0; i < KwCount; i++) begin
        same = (int'(KwLen[i]) == word_len);
        for (int j = 0; j < word_len; j++) begin
          if (word_text[j] != KwText[i][j]) same = 1'b0;
        end
        if (same) k = KindKw0 + KindW'(i);
      end
    end
    push_token(k, ErrNone);
    scan_state = ModeIdle;
  endfunction

  function automatic logic close_literal();
    scan_state = ModeIdle;
    if (bare_prefix || bad_tail) begin
      push_token(KindEof, ErrBadInt);
      stopped = 1'b1;
      return 1'b0;
    end
    push_token(KindInt, ErrNone);
    return 1'b1;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    char_cls_e cls;
    cls = char_class(c);
    open_span();
    move_past(c);
    case (cls)
      ClsSpace: ;
      ClsPunct: push_token(punct_code(c), ErrNone);
      ClsDigit: begin
        scan_state  = (c == "0") ? ModeZero : ModeDec;
        bare_prefix = 1'b0;
        bad_tail    = 1'b0;
      end
      ClsLetter, ClsScore: begin
        scan_state   = ModeWord;
        word_text[0] = c;
        word_len     = 1;
      end
      default: begin
        push_token(KindEof, ErrBadChar);
        stopped = 1'b1;
      end
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic pending;
    pending = 1'b0;
    case (scan_state)
      ModeWord: begin
        if (word_char(c)) begin
          if (word_len < KeepLen) word_text[word_len] = c;
          if (word_len <= KeepLen) word_len++;
          move_past(c);
        end else begin
          close_word();
          start_token(c);
        end
        return;
      end
      ModeZero: begin
        if (c == CharX || c == "X") begin
          scan_state  = ModeHexP;
          bare_prefix = 1'b1;
          move_past(c);
          return;
        end
        if (c == CharB || c == "B") begin
          scan_state  = ModeBinP;
          bare_prefix = 1'b1;
          move_past(c);
          return;
        end
        if (c >= "0" && c <= "7") begin
          scan_state = ModeOct;
          move_past(c);
          return;
        end
      end
      ModeHexP, ModeHex: begin
        if (hex_digit(c)) begin
          scan_state  = ModeHex;
          bare_prefix = 1'b0;
          pending     = 1'b1;
        end
      end
      ModeBinP, ModeBin: begin
        if (c == "0" || c == "1") begin
          scan_state  = ModeBin;
          bare_prefix = 1'b0;
          pending     = 1'b1;
        end
      end
      ModeOct:  pending = (c >= "0" && c <= "7");
      ModeDec:  pending = (char_class(c) == ClsDigit);
      ModeTail: pending = word_char(c);
      default: begin
        scan_state = ModeIdle;
        start_token(c);
        return;
      end
    endcase
    if (pending) begin
      move_past(c);
    end else if (word_char(c)) begin
      scan_state = ModeTail;
      bad_tail   = 1'b1;
      move_past(c);
    end else if (close_literal()) begin
      start_token(c);
    end
  endfunction

  function automatic void predict_tokens(input in_item_t it);
    out_item_t t;
    step_results = 0;
    if (it.ch_valid && !stopped) scan_byte(it.ch);
    if (it.end_of_source) begin
      if (!stopped) begin
        if (scan_state == ModeWord) close_word();
        else if (scan_state != ModeIdle) void'(close_literal());
      end
      if (!stopped) begin
        open_span();
        push_token(KindEof, ErrNone);
      end
      clear_state();
    end
    if (step_results > 0) begin
      t = tok_expected.pop_back();
      t.last = 1'b1;
      tok_expected.push_back(t);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (src_if.valid && src_if.ready) predict_tokens(src_if.data);
      if (tok_if.valid && tok_if.ready) begin
        if (tok_expected.size() == 0) begin
          mismatches++;
          $display("%0t: no token expected, got kind %0d err %0d", $time,
                   tok_if.data.kind, tok_if.data.err_code);
        end else begin
          want = tok_expected.pop_front();
          check_field("kind", 16'(want.kind), 16'(tok_if.data.kind));
          check_field("err_code", 16'(want.err_code), 16'(tok_if.data.err_code));
          check_field("start_index", want.start_index, tok_if.data.start_index);
          check_field("end_index", want.end_index, tok_if.data.end_index);
          check_field("start_line", want.start_line, tok_if.data.start_line);
          check_field("start_column", want.start_column, tok_if.data.start_column);
          check_field("end_line", want.end_line, tok_if.data.end_line);
          check_field("end_column", want.end_column, tok_if.data.end_column);
          check_field("last", 16'(want.last), 16'(tok_if.data.last));
        end
      end
    end
  end

  always @(negedge clk) tok_if.ready <= ($urandom_range(99) >= tok_stall_pct);

  task automatic send_item(input logic [7:0] c, input logic has_byte, input logic eos);
    in_item_t it;
    it = '{ch: c, ch_valid: has_byte, end_of_source: eos};
    while ($urandom_range(99) < src_gap_pct) begin
      src_if.valid <= 1'b0;
      @(negedge clk);
    end
    src_if.valid <= 1'b1;
    src_if.data  <= it;
    do @(posedge clk); while (!src_if.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic eos_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, eos_on_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic void put_run(ref logic [7:0] q[$], input string set, input int n);
    repeat (n) q.push_back(pick(set));
  endfunction

  function automatic void put_keyword(ref logic [7:0] q[$]);
    int k;
    k = $urandom_range(KwCount - 1);
    for (int j = 0; j < int'(KwLen[k]); j++) q.push_back(KwText[k][j]);
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (char_class(c) != ClsBad);
    return c;
  endfunction

  // returns 1 when the token needs a separator behind it
  function automatic logic put_token(ref logic [7:0] q[$]);
    case ($urandom_range(9))
      0: begin
        q.push_back(pick(Blanks));
        return 1'b0;
      end
      1, 2: begin
        q.push_back(pick(PunctChars));
        return 1'b0;
      end
      3: put_keyword(q);
      4: begin
        put_keyword(q);
        put_run(q, WordChars, $urandom_range(1, 3));
      end
      5: begin
        q.push_back(pick(WordHead));
        put_run(q, WordChars, $urandom_range(0, 8));
      end
      6: begin
        q.push_back("0");
        q.push_back($urandom_range(1) ? "x" : "X");
        put_run(q, HexDigits, $urandom_range(1, 4));
      end
      7: begin
        q.push_back("0");
        q.push_back($urandom_range(1) ? "b" : "B");
        put_run(q, "01", $urandom_range(1, 6));
      end
      8: begin
        q.push_back("0");
        put_run(q, OctDigits, $urandom_range(0, 3));
      end
      default: begin
        q.push_back(pick("123456789"));
        put_run(q, DecDigits, $urandom_range(0, 4));
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void put_noise(ref logic [7:0] q[$]);
    case ($urandom_range(4))
      0: begin
        q.push_back("0");
        q.push_back(pick("xX"));
      end
      1: begin
        q.push_back("0");
        q.push_back(pick("bB"));
      end
      2: begin
        put_run(q, DecDigits, $urandom_range(1, 3));
        q.push_back(pick(WordHead));
        put_run(q, WordChars, $urandom_range(0, 3));
      end
      3: begin
        q.push_back("0");
        q.push_back(pick("xXbB"));
        q.push_back("1");
        q.push_back(pick("gGzZ_2"));
      end
      default: q.push_back(bad_byte());
    endcase
  endfunction

  function automatic void put_sep(ref logic [7:0] q[$]);
    q.push_back($urandom_range(9) < 6 ? pick(Blanks) : pick(PunctChars));
  endfunction

  task automatic test_punctuators();
    send_text(PunctChars, 1'b1);
  endtask

  task automatic test_errors_and_halt();
    send_text("x\t0x", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("a;", 1'b1);
    send_text("\n7", 1'b1);
  endtask

  task automatic test_random_texts(input int budget);
    logic [7:0] text [$];
    int         n_tok, noise_at, spent;
    logic       open_tok, eos_on_byte;
    spent = 0;
    while (spent < budget) begin
      text     = {};
      n_tok    = $urandom_range(1, 10);
      noise_at = ($urandom_range(3) == 0) ? $urandom_range(n_tok - 1) : -1;
      for (int t = 0; t < n_tok; t++) begin
        if (t == noise_at) begin
          put_noise(text);
          open_tok = 1'b1;
        end else begin
          open_tok = put_token(text);
        end
        if (open_tok && (t < n_tok - 1 || $urandom_range(1))) put_sep(text);
      end
      if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      eos_on_byte = $urandom_range(1);
      for (int i = 0; i < text.size(); i++) begin
        if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(text[i], 1'b1, eos_on_byte && (i == text.size() - 1));
      end
      if (!eos_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
      spent += text.size();
    end
  endtask

  initial begin
    int drain;
    clear_state();
    rst_n        = 1'b0;
    src_if.valid = 1'b0;
    src_if.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_punctuators();
    test_errors_and_halt();
    test_random_texts(120);

    src_gap_pct   = 60;
    tok_stall_pct = 27;
    test_random_texts(120);

    src_gap_pct   = 0;
    tok_stall_pct = 0;
    test_random_texts(110);

    src_if.valid <= 1'b0;
    drain = 0;
    while (tok_expected.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (tok_expected.size() != 0) begin
      mismatches++;
      $display("%0t: %0d tokens expected, got 0", $time, tok_expected.size());
    end
    if (mismatches == 0) begin
      $display("** source_lexer_tokenizer_unit: PASSED **");
    end else begin
      $display("** source_lexer_tokenizer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** source_lexer_tokenizer_unit: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/slt_pkg.sv
rtl/slt_stream_if.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/source_lexer_tokenizer_unit.sv
dv/source_lexer_tokenizer_unit_tb.sv
